// File: rtl/skt_pkg.sv
// Shared constants, codes and item types for the sorted key table.
package skt_pkg;

  localparam int unsigned Capacity = 256;
  localparam int unsigned KeyWidth = 32;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = IdxW + 1;

  localparam logic [1:0] OP_APPEND    = 2'd0;
  localparam logic [1:0] OP_INSERT_AT = 2'd1;
  localparam logic [1:0] OP_INSERT_SR = 2'd2;
  localparam logic [1:0] OP_FIND      = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_POS  = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] key;
    logic [7:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] where;
    logic [8:0] count;
  } out_item_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                place;
    logic                cmp;
    logic [IdxW-1:0]     at;
    logic [KeyWidth-1:0] key;
  } cell_ctrl_t;

endpackage

// File: rtl/sorted_key_table.sv
// Top level of the sorted key table: sequencer and a row of key cells.
//
//  Channel | Direction | Handshake               | Payload
//  in      | input     | in_valid_i / in_ready_o | in_item_i  (opcode, key, position)
//  out     | output    | out_valid_o/out_ready_i | out_item_o (status, where, count)
//
// An append or an insert-at passes through the placement state and then the result; an
// error, or a find on an empty table, goes straight to the result. A find takes a compare
// step in the cells, then one binary-search probe per cycle, and the result. A sorted
// insert adds a placement step after its search; into an empty table it places at once.
// Placement shifts every cell above the target in the same cycle as the new key is written.
// Reset clears the fill count and the handshake state; cell contents are left as they are.
// A stalled output holds the next finished item in the sequencer until the register frees.
module sorted_key_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  skt_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output skt_pkg::out_item_t  out_item_o
);

  skt_pkg::cell_ctrl_t          cell_ctrl;
  logic [skt_pkg::Capacity-1:0] lt_vec;
  logic [skt_pkg::Capacity-1:0] gt_vec;
  logic [skt_pkg::KeyWidth-1:0] cell_key [skt_pkg::Capacity];

  skt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cell_ctrl_o (cell_ctrl),
    .lt_i        (lt_vec),
    .gt_i        (gt_vec)
  );

  for (genvar g = 0; g < skt_pkg::Capacity; g++) begin : g_cell
    logic [skt_pkg::KeyWidth-1:0] left_key;

    if (g == 0) begin : g_first
      assign left_key = '0;
    end else begin : g_rest
      assign left_key = cell_key[g-1];
    end

    skt_cell u_cell (
      .clk_i      (clk_i),
      .idx_i      (skt_pkg::IdxW'(g)),
      .ctrl_i     (cell_ctrl),
      .left_key_i (left_key),
      .key_o      (cell_key[g]),
      .lt_o       (lt_vec[g]),
      .gt_o       (gt_vec[g])
    );
  end

endmodule

// File: rtl/skt_cell.sv
// One table cell: holds a key, shifts up from its lower neighbour and compares.
module skt_cell (
  input  logic                         clk_i,
  input  logic [skt_pkg::IdxW-1:0]     idx_i,
  input  skt_pkg::cell_ctrl_t          ctrl_i,
  input  logic [skt_pkg::KeyWidth-1:0] left_key_i,
  output logic [skt_pkg::KeyWidth-1:0] key_o,
  output logic                         lt_o,
  output logic                         gt_o
);

  logic [skt_pkg::KeyWidth-1:0] key_q, key_d;
  logic                         lt_q, lt_d;
  logic                         gt_q, gt_d;

  always_comb begin
    key_d = key_q;
    lt_d  = lt_q;
    gt_d  = gt_q;
    if (ctrl_i.place) begin
      if (idx_i > ctrl_i.at) begin
        key_d = left_key_i;
      end else if (idx_i == ctrl_i.at) begin
        key_d = ctrl_i.key;
      end
    end
    if (ctrl_i.cmp) begin
      lt_d = key_q < ctrl_i.key;
      gt_d = key_q > ctrl_i.key;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    lt_q  <= lt_d;
    gt_q  <= gt_d;
  end

  assign key_o = key_q;
  assign lt_o  = lt_q;
  assign gt_o  = gt_q;

endmodule

// File: rtl/skt_ctrl.sv
// Sequencer: takes items, runs the binary search over the cell flags and drives placement.
module skt_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  skt_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output skt_pkg::out_item_t           out_item_o,
  output skt_pkg::cell_ctrl_t          cell_ctrl_o,
  input  logic [skt_pkg::Capacity-1:0] lt_i,
  input  logic [skt_pkg::Capacity-1:0] gt_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_SEARCH,
    S_PLACE,
    S_RESP
  } state_e;

  state_e                       state_q, state_d;
  logic [1:0]                   op_q, op_d;
  logic [skt_pkg::KeyWidth-1:0] key_q, key_d;
  logic [skt_pkg::CntW-1:0]     count_q, count_d;
  logic [skt_pkg::IdxW-1:0]     low_q, low_d;
  logic [skt_pkg::IdxW-1:0]     high_q, high_d;
  logic [1:0]                   status_q, status_d;
  logic [skt_pkg::IdxW-1:0]     where_q, where_d;
  logic                         out_valid_q, out_valid_d;
  skt_pkg::out_item_t           out_q, out_d;

  logic [skt_pkg::CntW-1:0]     mid_sum;
  logic [skt_pkg::IdxW-1:0]     mid;
  logic                         fin;
  logic                         fin_hit;
  logic [skt_pkg::IdxW-1:0]     fin_idx;
  logic [skt_pkg::CntW-1:0]     fin_next;

  assign mid_sum  = {1'b0, low_q} + {1'b0, high_q};
  assign mid      = mid_sum[skt_pkg::CntW-1:1];
  assign fin_next = {1'b0, fin_idx} + skt_pkg::CntW'(1);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    count_d     = count_q;
    low_d       = low_q;
    high_d      = high_q;
    status_d    = status_q;
    where_d     = where_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    fin         = 1'b0;
    fin_hit     = 1'b0;
    fin_idx     = low_q;

    cell_ctrl_o.place = 1'b0;
    cell_ctrl_o.cmp   = 1'b0;
    cell_ctrl_o.at    = where_q;
    cell_ctrl_o.key   = key_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = in_item_i.opcode;
          key_d    = in_item_i.key[skt_pkg::KeyWidth-1:0];
          status_d = skt_pkg::ST_OK;
          where_d  = '0;
          if (in_item_i.opcode == skt_pkg::OP_FIND) begin
            if (count_q == '0) begin
              status_d = skt_pkg::ST_MISS;
              state_d  = S_RESP;
            end else begin
              state_d = S_CMP;
            end
          end else if (count_q == skt_pkg::CntW'(skt_pkg::Capacity)) begin
            status_d = skt_pkg::ST_FULL;
            state_d  = S_RESP;
          end else if (in_item_i.opcode == skt_pkg::OP_APPEND) begin
            where_d = count_q[skt_pkg::IdxW-1:0];
            state_d = S_PLACE;
          end else if (in_item_i.opcode == skt_pkg::OP_INSERT_AT) begin
            if ({1'b0, in_item_i.position} > count_q) begin
              status_d = skt_pkg::ST_POS;
              state_d  = S_RESP;
            end else begin
              where_d = in_item_i.position;
              state_d = S_PLACE;
            end
          end else if (count_q == '0) begin
            state_d = S_PLACE;
          end else begin
            state_d = S_CMP;
          end
        end
      end

      S_CMP: begin
        cell_ctrl_o.cmp = 1'b1;
        low_d   = '0;
        high_d  = skt_pkg::IdxW'(count_q - skt_pkg::CntW'(1));
        state_d = S_SEARCH;
      end

      S_SEARCH: begin
        if (high_q > low_q) begin
          if (gt_i[mid]) begin
            high_d = mid;
          end else if (lt_i[mid]) begin
            low_d = mid + skt_pkg::IdxW'(1);
          end else begin
            fin     = 1'b1;
            fin_hit = 1'b1;
            fin_idx = mid;
          end
        end else begin
          fin     = 1'b1;
          fin_hit = !lt_i[low_q] && !gt_i[low_q];
          fin_idx = low_q;
        end
        if (fin) begin
          if (op_q == skt_pkg::OP_FIND) begin
            status_d = fin_hit ? skt_pkg::ST_OK : skt_pkg::ST_MISS;
            where_d  = fin_hit ? fin_idx : '0;
            state_d  = S_RESP;
          end else begin
            // A miss whose final entry is below the key places just after it.
            if (!fin_hit && lt_i[fin_idx]) begin
              where_d = fin_next[skt_pkg::IdxW-1:0];
            end else begin
              where_d = fin_idx;
            end
            state_d = S_PLACE;
          end
        end
      end

      S_PLACE: begin
        cell_ctrl_o.place = 1'b1;
        count_d = count_q + skt_pkg::CntW'(1);
        state_d = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.status = status_q;
          out_d.where  = where_q;
          out_d.count  = count_q;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    low_q    <= low_d;
    high_q   <= high_d;
    status_q <= status_d;
    where_q  <= where_d;
    out_q    <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
